### rtl/bhsb_pkg.sv
// Package for the bucket handshake status blinker.
// Holds command and phase codes, register map, reset values and shared types.
// No dependencies.
`timescale 1ns / 1ps

package bhsb_pkg;

  localparam int unsigned CFG_AW = 5;
  localparam int unsigned CFG_DW = 32;

  typedef enum logic [2:0] {
    CMD_TICK     = 3'd0,
    CMD_RESEND   = 3'd1,
    CMD_OK       = 3'd2,
    CMD_REQUEST  = 3'd3,
    CMD_SENT     = 3'd4,
    CMD_RAISE    = 3'd5
  } cmd_t;

  localparam logic [2:0] PHASE_INIT      = 3'd0;
  localparam logic [2:0] PHASE_PARAMS    = 3'd1;
  localparam logic [2:0] PHASE_FRQ       = 3'd2;
  localparam logic [2:0] PHASE_DATA      = 3'd3;
  localparam logic [2:0] PHASE_REQUESTED = 3'd4;

  // register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_PAUSE     = 3'd0;
  localparam logic [2:0] REG_CODE_TGL  = 3'd1;
  localparam logic [2:0] REG_OK_TGL    = 3'd2;
  localparam logic [2:0] REG_WAIT_TGL  = 3'd3;
  localparam logic [2:0] REG_LINK_TO   = 3'd4;
  localparam logic [2:0] REG_FIRST_ID  = 3'd5;
  localparam logic [2:0] REG_UNK_CODE  = 3'd6;

  localparam logic [15:0] RST_PAUSE    = 16'd800;
  localparam logic [15:0] RST_CODE_TGL = 16'd200;
  localparam logic [15:0] RST_OK_TGL   = 16'd500;
  localparam logic [15:0] RST_WAIT_TGL = 16'd2000;
  localparam logic [15:0] RST_LINK_TO  = 16'd2000;
  localparam logic [7:0]  RST_FIRST_ID = 8'd0;
  localparam logic [3:0]  RST_UNK_CODE = 4'd1;

  typedef struct packed {
    logic [15:0] pause_ms;
    logic [15:0] code_toggle_ms;
    logic [15:0] ok_toggle_ms;
    logic [15:0] wait_toggle_ms;
    logic [15:0] link_timeout_ms;
    logic [7:0]  first_bucket_id;
    logic [3:0]  unknown_bucket_code;
  } cfg_t;

  typedef struct packed {
    logic [3:0] error_code;
    logic [7:0] bucket_number;
    logic       from_logger;
    logic [2:0] command;
  } item_t;

  typedef struct packed {
    logic       link_alive;
    logic       buckets_ready;
    logic [3:0] latched_fault;
    logic       led_on;
  } result_t;

endpackage

### rtl/bhsb_cfg.sv
// Configuration register file with an APB-style slave port.
// Depends on bhsb_pkg.
`timescale 1ns / 1ps

module bhsb_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bhsb_pkg::CFG_AW-1:0] paddr,
  input  logic [bhsb_pkg::CFG_DW-1:0] pwdata,
  output logic [bhsb_pkg::CFG_DW-1:0] prdata,
  output logic                        pready,
  output bhsb_pkg::cfg_t              cfg
);
  import bhsb_pkg::*;

  cfg_t       cfg_r;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[CFG_AW-1:2];
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pause_ms            <= RST_PAUSE;
      cfg_r.code_toggle_ms      <= RST_CODE_TGL;
      cfg_r.ok_toggle_ms        <= RST_OK_TGL;
      cfg_r.wait_toggle_ms      <= RST_WAIT_TGL;
      cfg_r.link_timeout_ms     <= RST_LINK_TO;
      cfg_r.first_bucket_id     <= RST_FIRST_ID;
      cfg_r.unknown_bucket_code <= RST_UNK_CODE;
    end else if (wr_en) begin
      case (reg_idx)
        REG_PAUSE:    cfg_r.pause_ms            <= pwdata[15:0];
        REG_CODE_TGL: cfg_r.code_toggle_ms      <= pwdata[15:0];
        REG_OK_TGL:   cfg_r.ok_toggle_ms        <= pwdata[15:0];
        REG_WAIT_TGL: cfg_r.wait_toggle_ms      <= pwdata[15:0];
        REG_LINK_TO:  cfg_r.link_timeout_ms     <= pwdata[15:0];
        REG_FIRST_ID: cfg_r.first_bucket_id     <= pwdata[7:0];
        REG_UNK_CODE: cfg_r.unknown_bucket_code <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_PAUSE:    prdata = {16'd0, cfg_r.pause_ms};
      REG_CODE_TGL: prdata = {16'd0, cfg_r.code_toggle_ms};
      REG_OK_TGL:   prdata = {16'd0, cfg_r.ok_toggle_ms};
      REG_WAIT_TGL: prdata = {16'd0, cfg_r.wait_toggle_ms};
      REG_LINK_TO:  prdata = {16'd0, cfg_r.link_timeout_ms};
      REG_FIRST_ID: prdata = {24'd0, cfg_r.first_bucket_id};
      REG_UNK_CODE: prdata = {28'd0, cfg_r.unknown_bucket_code};
      default:      prdata = '0;
    endcase
  end

endmodule

### rtl/bhsb_core.sv
// Handshake state, timers and LED rule; updates state for one transaction.
// Depends on bhsb_pkg. Result reflects the state after the update.
`timescale 1ns / 1ps

module bhsb_core #(
  parameter int unsigned BUCKET_COUNT = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  bhsb_pkg::item_t   item,
  input  bhsb_pkg::cfg_t    cfg,
  output bhsb_pkg::result_t res
);
  import bhsb_pkg::*;

  localparam int unsigned IDX_W = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;

  logic [31:0] now_r, now_nxt;
  logic [31:0] last_tgl_r, last_tgl_nxt;
  logic [31:0] last_req_r, last_req_nxt;
  logic [4:0]  blinks_r, blinks_nxt;
  logic        led_r, led_nxt;
  logic [3:0]  fault_r, fault_nxt;
  logic [2:0]  phase_r   [BUCKET_COUNT];
  logic [2:0]  phase_nxt [BUCKET_COUNT];

  logic [8:0]       id_diff;
  logic             known;
  logic [IDX_W-1:0] bidx;
  logic [31:0]      now_inc;
  logic [31:0]      since;
  logic             ready_cur, ready_nxt;
  logic             alive_tick;
  logic [15:0]      tgl_ms;

  assign id_diff = {1'b0, item.bucket_number} - {1'b0, cfg.first_bucket_id};
  assign known   = !id_diff[8] && (id_diff[7:0] < 8'(BUCKET_COUNT));
  assign bidx    = id_diff[IDX_W-1:0];

  assign now_inc    = now_r + 32'd1;
  assign since      = now_inc - last_tgl_r;
  assign alive_tick = (now_inc - last_req_r) < {16'd0, cfg.link_timeout_ms};

  always_comb begin
    ready_cur = 1'b1;
    for (int i = 0; i < BUCKET_COUNT; i++) begin
      if (phase_r[i] <= PHASE_FRQ) ready_cur = 1'b0;
    end
  end

  assign tgl_ms = (ready_cur && alive_tick) ? cfg.ok_toggle_ms : cfg.wait_toggle_ms;

  always_comb begin
    now_nxt      = now_r;
    last_tgl_nxt = last_tgl_r;
    last_req_nxt = last_req_r;
    blinks_nxt   = blinks_r;
    led_nxt      = led_r;
    fault_nxt    = fault_r;
    for (int i = 0; i < BUCKET_COUNT; i++) phase_nxt[i] = phase_r[i];

    case (item.command)
      CMD_TICK: begin
        now_nxt = now_inc;
        if (fault_r != 4'd0) begin
          if (blinks_r == 5'd0) begin
            if (since >= {16'd0, cfg.pause_ms}) begin
              led_nxt      = 1'b0;
              last_tgl_nxt = now_inc;
              blinks_nxt   = {fault_r, 1'b0};
            end
          end else if (since >= {16'd0, cfg.code_toggle_ms}) begin
            led_nxt      = !led_r;
            last_tgl_nxt = now_inc;
            blinks_nxt   = blinks_r - 5'd1;
          end
        end else if (since >= {16'd0, tgl_ms}) begin
          led_nxt      = !led_r;
          last_tgl_nxt = now_inc;
        end
      end
      CMD_RESEND: begin
        if (item.from_logger) begin
          for (int i = 0; i < BUCKET_COUNT; i++) phase_nxt[i] = PHASE_PARAMS;
        end
      end
      CMD_OK: begin
        if (item.from_logger) begin
          if (!known) begin
            fault_nxt = cfg.unknown_bucket_code;
          end else begin
            for (int i = 0; i < BUCKET_COUNT; i++) begin
              if (IDX_W'(i) == bidx && phase_r[i] <= PHASE_FRQ) phase_nxt[i] = PHASE_FRQ;
            end
          end
        end
      end
      CMD_REQUEST: begin
        if (!known) begin
          fault_nxt = cfg.unknown_bucket_code;
        end else begin
          last_req_nxt = now_r;
          for (int i = 0; i < BUCKET_COUNT; i++) begin
            if (IDX_W'(i) == bidx) phase_nxt[i] = PHASE_REQUESTED;
          end
        end
      end
      CMD_SENT: begin
        if (known) begin
          for (int i = 0; i < BUCKET_COUNT; i++) begin
            if (IDX_W'(i) == bidx && phase_r[i] == PHASE_REQUESTED) phase_nxt[i] = PHASE_DATA;
          end
        end
      end
      CMD_RAISE: fault_nxt = item.error_code;
      default: ;
    endcase
  end

  always_comb begin
    ready_nxt = 1'b1;
    for (int i = 0; i < BUCKET_COUNT; i++) begin
      if (phase_nxt[i] <= PHASE_FRQ) ready_nxt = 1'b0;
    end
  end

  assign res.led_on        = led_nxt;
  assign res.latched_fault = fault_nxt;
  assign res.buckets_ready = ready_nxt;
  assign res.link_alive    = (now_nxt - last_req_nxt) < {16'd0, cfg.link_timeout_ms};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r      <= '0;
      last_tgl_r <= '0;
      last_req_r <= '0;
      blinks_r   <= '0;
      led_r      <= 1'b0;
      fault_r    <= '0;
      for (int i = 0; i < BUCKET_COUNT; i++) phase_r[i] <= PHASE_INIT;
    end else if (en) begin
      now_r      <= now_nxt;
      last_tgl_r <= last_tgl_nxt;
      last_req_r <= last_req_nxt;
      blinks_r   <= blinks_nxt;
      led_r      <= led_nxt;
      fault_r    <= fault_nxt;
      for (int i = 0; i < BUCKET_COUNT; i++) phase_r[i] <= phase_nxt[i];
    end
  end

endmodule

### rtl/bucket_handshake_status_blinker_unit.sv
// Bucket handshake status blinker, top level.
// Each transaction passes an input register and then a result register.
// Throughput: one transaction per cycle while out_tready holds; the core state update is a single pass.
// Reset (rst_n, synchronous, active low) clears all timers, the fault latch, the LED,
// sets every bucket phase to PHASE_INIT, and loads the register reset values.
// Depends on bhsb_pkg, bhsb_cfg and bhsb_core.
`timescale 1ns / 1ps

module bucket_handshake_status_blinker_unit #(
  parameter int unsigned BUCKET_COUNT = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // command[2:0], from_logger[3], bucket_number[11:4], error_code[15:12]
  input  logic [15:0]                 in_tdata,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // led_on[0], latched_fault[4:1], buckets_ready[5], link_alive[6], zero[7]
  output logic [7:0]                  out_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [bhsb_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [bhsb_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [bhsb_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                        cfg_pready
);
  import bhsb_pkg::*;

  cfg_t    cfg;
  item_t   item_r;
  logic    item_vld_r;
  result_t res;
  result_t res_r;
  logic    out_vld_r;
  logic    adv;

  // input stage moves on whenever the result register is free or being drained
  assign adv       = item_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !item_vld_r || adv;

  bhsb_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  bhsb_core #(
    .BUCKET_COUNT (BUCKET_COUNT)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .item  (item_r),
    .cfg   (cfg),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (in_tready) item_vld_r <= in_tvalid;
      if (adv) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) item_r <= item_t'(in_tdata);
    if (adv) res_r <= res;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {1'b0, res_r};

endmodule
